// ----- rtl/tfe_pkg.sv -----
package tfe_pkg;

  localparam int unsigned LEVEL_FRAC_BITS = 16;
  localparam int unsigned CMD_W           = 2;
  localparam int unsigned TIME_W          = 16;
  localparam int unsigned ELAPSED_W       = 18;
  localparam int unsigned COLOR_W         = 32;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned CFG_DATA_W      = 32;
  localparam logic [COLOR_W-1:0] COLOR_RESET = 32'hFFFF_FFFF;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 2'd0,
    CMD_ARM_OUT = 2'd1,
    CMD_ARM_IN  = 2'd2,
    CMD_RSVD    = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OUT_RISE = 3'd0,
    CFG_OUT_HOLD = 3'd1,
    CFG_OUT_FALL = 3'd2,
    CFG_IN_RISE  = 3'd3,
    CFG_IN_HOLD  = 3'd4,
    CFG_IN_FALL  = 3'd5,
    CFG_COLOR    = 3'd6,
    CFG_NONE     = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic accept;
    logic arm;
    logic eval;
    logic div_step;
    logic fin;
    logic sel_in;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic need_div;
    logic div_last;
  } ctrl_sts_t;

endpackage

// ----- rtl/tfe_if.sv -----
interface tfe_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [tfe_pkg::CMD_W-1:0]     cmd;
  logic [tfe_pkg::TIME_W-1:0]    elapsed_ticks;

  modport source (output valid, cmd, elapsed_ticks, input ready);
  modport sink   (input valid, cmd, elapsed_ticks, output ready);
endinterface

interface tfe_res_if #(
  parameter int unsigned LVL_W = tfe_pkg::LEVEL_FRAC_BITS + 1
);
  logic                          valid;
  logic                          ready;
  logic                          tint_enable;
  logic [LVL_W-1:0]              tint_level;
  logic [tfe_pkg::COLOR_W-1:0]   overlay_color;
  logic                          out_active;
  logic                          in_active;

  modport source (output valid, tint_enable, tint_level, overlay_color, out_active,
                  in_active, input ready);
  modport sink   (input valid, tint_enable, tint_level, overlay_color, out_active,
                  in_active, output ready);
endinterface

interface tfe_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tfe_pkg::CFG_IDX_W-1:0]   index;
  logic [tfe_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/tfe_ctrl.sv -----
module tfe_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  input  tfe_pkg::ctrl_sts_t  sts_i,
  output tfe_pkg::ctrl_cmd_t  ctrl_o
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_ARM      = 8'b0000_0010,
    S_OUT_EVAL = 8'b0000_0100,
    S_OUT_DIV  = 8'b0000_1000,
    S_OUT_FIN  = 8'b0001_0000,
    S_IN_EVAL  = 8'b0010_0000,
    S_IN_DIV   = 8'b0100_0000,
    S_IN_FIN   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;
  logic   res_valid_q, res_valid_d;
  logic   load;

  assign cmd_ready_o = (state_q == S_IDLE) && !done_q;
  assign res_valid_o = res_valid_q;
  assign load        = done_q && (!res_valid_q || res_ready_i);

  always_comb begin
    state_d = state_q;
    done_d  = done_q;
    ctrl_o  = '0;
    ctrl_o.load = load;
    if (load) begin
      done_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && !done_q) begin
          ctrl_o.accept = 1'b1;
          state_d = S_ARM;
        end
      end
      S_ARM: begin
        ctrl_o.arm = 1'b1;
        if (sts_i.is_tick) begin
          state_d = S_OUT_EVAL;
        end else begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_OUT_EVAL: begin
        ctrl_o.eval = 1'b1;
        state_d = sts_i.need_div ? S_OUT_DIV : S_OUT_FIN;
      end
      S_OUT_DIV: begin
        ctrl_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_OUT_FIN;
        end
      end
      S_OUT_FIN: begin
        ctrl_o.fin = 1'b1;
        state_d = S_IN_EVAL;
      end
      S_IN_EVAL: begin
        ctrl_o.eval   = 1'b1;
        ctrl_o.sel_in = 1'b1;
        state_d = sts_i.need_div ? S_IN_DIV : S_IN_FIN;
      end
      S_IN_DIV: begin
        ctrl_o.div_step = 1'b1;
        ctrl_o.sel_in   = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_IN_FIN;
        end
      end
      S_IN_FIN: begin
        ctrl_o.fin    = 1'b1;
        ctrl_o.sel_in = 1'b1;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (load) begin
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      done_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      done_q      <= done_d;
      res_valid_q <= res_valid_d;
    end
  end

endmodule

// ----- rtl/tfe_datapath.sv -----
module tfe_datapath #(
  parameter int unsigned LevelFracBits = tfe_pkg::LEVEL_FRAC_BITS,
  localparam int unsigned LvlW = LevelFracBits + 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tfe_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [tfe_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic [tfe_pkg::CMD_W-1:0]         cmd_i,
  input  logic [tfe_pkg::TIME_W-1:0]        ticks_i,
  input  tfe_pkg::ctrl_cmd_t                ctrl_i,
  output tfe_pkg::ctrl_sts_t                sts_o,
  output logic                              tint_enable_o,
  output logic [LvlW-1:0]                   tint_level_o,
  output logic [tfe_pkg::COLOR_W-1:0]       overlay_color_o,
  output logic                              out_active_o,
  output logic                              in_active_o
);

  localparam int unsigned TW   = tfe_pkg::TIME_W;
  localparam int unsigned EW   = tfe_pkg::ELAPSED_W;
  localparam int unsigned CW   = tfe_pkg::COLOR_W;
  localparam int unsigned CntW = $clog2(LevelFracBits + 1);
  localparam logic [LvlW-1:0] LvlOne = {1'b1, {LevelFracBits{1'b0}}};

  typedef enum logic [1:0] {
    KIND_SKIP    = 2'd0,
    KIND_STOP    = 2'd1,
    KIND_LEVEL   = 2'd2,
    KIND_NOLEVEL = 2'd3
  } kind_e;

  // config
  logic [TW-1:0] out_rise_q, out_hold_q, out_fall_q;
  logic [TW-1:0] in_rise_q, in_hold_q, in_fall_q;
  logic [CW-1:0] color_q;

  // envelope state
  logic [EW-1:0]   out_el_q, in_el_q;
  logic            out_run_q, in_run_q;
  logic            tint_on_q;
  logic [LvlW-1:0] tint_val_q;
  logic [CW-1:0]   overlay_q;

  // item and evaluation
  logic [tfe_pkg::CMD_W-1:0] cmd_q;
  logic [TW-1:0]   ticks_q;
  kind_e           kind_q, kind_d;
  logic [EW-1:0]   e_q;
  logic            cmpl_q;
  logic [TW:0]     rem_q, rem_d;
  logic [TW-1:0]   den_q, den_d;
  logic [LvlW-1:0] quo_q, quo_d;
  logic [CntW-1:0] cnt_q;

  // result register
  logic            r_tint_on_q, r_out_run_q, r_in_run_q;
  logic [LvlW-1:0] r_tint_val_q;
  logic [CW-1:0]   r_overlay_q;

  logic [TW-1:0] r_sel, h_sel, f_sel;
  logic [EW-1:0] el_sel, e_sum, rh, rhf, d;
  logic          run_sel, need_div;
  logic          ge;
  logic [TW:0]   diff, nxt;
  logic [CW-1:0] scaled;

  assign r_sel   = ctrl_i.sel_in ? in_rise_q : out_rise_q;
  assign h_sel   = ctrl_i.sel_in ? in_hold_q : out_hold_q;
  assign f_sel   = ctrl_i.sel_in ? in_fall_q : out_fall_q;
  assign el_sel  = ctrl_i.sel_in ? in_el_q   : out_el_q;
  assign run_sel = ctrl_i.sel_in ? in_run_q  : out_run_q;

  assign e_sum = el_sel + EW'(ticks_q);
  assign rh    = EW'(r_sel) + EW'(h_sel);
  assign rhf   = rh + EW'(f_sel);
  assign d     = e_sum - rh;

  always_comb begin
    kind_d   = KIND_LEVEL;
    need_div = 1'b0;
    rem_d    = '0;
    den_d    = r_sel;
    quo_d    = LvlOne;
    if (!run_sel) begin
      kind_d = KIND_SKIP;
    end else if (r_sel == '0) begin
      kind_d = KIND_STOP;
    end else if (e_sum >= rh) begin
      if ((f_sel != '0) && (d <= EW'(f_sel))) begin
        need_div = 1'b1;
        rem_d    = {1'b0, f_sel - d[TW-1:0]};
        den_d    = f_sel;
      end else begin
        kind_d = KIND_NOLEVEL;
        quo_d  = '0;
      end
    end else if (e_sum <= EW'(r_sel)) begin
      need_div = 1'b1;
      rem_d    = {1'b0, e_sum[TW-1:0]};
    end
  end

  // restoring divider, one quotient bit per cycle, MSB first
  assign ge   = rem_q >= {1'b0, den_q};
  assign diff = rem_q - {1'b0, den_q};
  assign nxt  = ge ? diff : rem_q;

  assign sts_o.is_tick  = (cmd_q == tfe_pkg::CMD_TICK);
  assign sts_o.need_div = need_div;
  assign sts_o.div_last = (cnt_q == CntW'(LevelFracBits));

  for (genvar c = 0; c < 4; c++) begin : g_scale
    logic [LvlW+7:0] prod;
    assign prod = {{(LevelFracBits+1){1'b0}}, color_q[8*c +: 8]} * {8'd0, quo_q};
    assign scaled[8*c +: 8] = prod[LevelFracBits +: 8];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_rise_q <= '0;
      out_hold_q <= '0;
      out_fall_q <= '0;
      in_rise_q  <= '0;
      in_hold_q  <= '0;
      in_fall_q  <= '0;
      color_q    <= tfe_pkg::COLOR_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tfe_pkg::CFG_OUT_RISE: out_rise_q <= cfg_data_i[TW-1:0];
        tfe_pkg::CFG_OUT_HOLD: out_hold_q <= cfg_data_i[TW-1:0];
        tfe_pkg::CFG_OUT_FALL: out_fall_q <= cfg_data_i[TW-1:0];
        tfe_pkg::CFG_IN_RISE:  in_rise_q  <= cfg_data_i[TW-1:0];
        tfe_pkg::CFG_IN_HOLD:  in_hold_q  <= cfg_data_i[TW-1:0];
        tfe_pkg::CFG_IN_FALL:  in_fall_q  <= cfg_data_i[TW-1:0];
        tfe_pkg::CFG_COLOR:    color_q    <= cfg_data_i[CW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_el_q   <= '0;
      in_el_q    <= '0;
      out_run_q  <= 1'b0;
      in_run_q   <= 1'b0;
      tint_on_q  <= 1'b0;
      tint_val_q <= '0;
      overlay_q  <= '0;
      cmd_q      <= tfe_pkg::CMD_RSVD;
      kind_q     <= KIND_SKIP;
      cnt_q      <= '0;
    end else begin
      if (ctrl_i.accept) begin
        cmd_q <= cmd_i;
      end
      if (ctrl_i.arm) begin
        if (cmd_q == tfe_pkg::CMD_ARM_OUT) begin
          out_el_q  <= '0;
          out_run_q <= (out_rise_q != '0);
        end else if (cmd_q == tfe_pkg::CMD_ARM_IN) begin
          in_el_q  <= '0;
          in_run_q <= (in_rise_q != '0);
        end
      end
      if (ctrl_i.eval) begin
        kind_q <= kind_d;
        cnt_q  <= '0;
      end
      if (ctrl_i.div_step) begin
        cnt_q <= cnt_q + CntW'(1);
      end
      if (ctrl_i.fin && !ctrl_i.sel_in) begin
        case (kind_q)
          KIND_STOP: begin
            out_run_q <= 1'b0;
            out_el_q  <= '0;
          end
          KIND_LEVEL, KIND_NOLEVEL: begin
            if (kind_q == KIND_LEVEL) begin
              tint_val_q <= quo_q;
            end
            if (cmpl_q) begin
              tint_on_q <= 1'b0;
              out_run_q <= 1'b0;
              out_el_q  <= '0;
            end else begin
              out_el_q <= e_q;
              if (kind_q == KIND_LEVEL) begin
                tint_on_q <= 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      if (ctrl_i.fin && ctrl_i.sel_in) begin
        case (kind_q)
          KIND_STOP: begin
            in_run_q <= 1'b0;
            in_el_q  <= '0;
          end
          KIND_LEVEL, KIND_NOLEVEL: begin
            if (cmpl_q) begin
              overlay_q <= '0;
              in_run_q  <= 1'b0;
              in_el_q   <= '0;
            end else begin
              in_el_q   <= e_q;
              overlay_q <= scaled;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      ticks_q <= ticks_i;
    end
    if (ctrl_i.eval) begin
      e_q    <= e_sum;
      cmpl_q <= (e_sum >= rhf);
      rem_q  <= rem_d;
      den_q  <= den_d;
      quo_q  <= quo_d;
    end else if (ctrl_i.div_step) begin
      rem_q <= {nxt[TW-1:0], 1'b0};
      quo_q <= {quo_q[LvlW-2:0], ge};
    end
    if (ctrl_i.load) begin
      r_tint_on_q  <= tint_on_q;
      r_tint_val_q <= tint_val_q;
      r_overlay_q  <= overlay_q;
      r_out_run_q  <= out_run_q;
      r_in_run_q   <= in_run_q;
    end
  end

  assign tint_enable_o   = r_tint_on_q;
  assign tint_level_o    = r_tint_val_q;
  assign overlay_color_o = r_overlay_q;
  assign out_active_o    = r_out_run_q;
  assign in_active_o     = r_in_run_q;

endmodule

// ----- rtl/trapezoid_fade_envelope.sv -----
// Fade-out tint and fade-in color overlay, each a rise/hold/fall envelope.
// Channels:
//   cfg_i : register writes (index, data), always ready. Write only while idle.
//   cmd_i : one beat per frame or arm command (cmd, elapsed_ticks).
//   res_o : one beat per cmd beat with the state after that command.
// Steps, accept to result valid:
//   arm or reserved cmd : arm, then the result register is loaded.
//   frame tick          : arm, then evaluate, divide if needed and finish for
//                         fade-out, then again for fade-in; each envelope level
//                         that lies on a ramp takes one restoring division, one
//                         quotient bit per cycle, on a single shared divider.
// Throughput: one cmd beat at a time; the next beat is taken once the
//   current one has been handed to the result register.
// The result register holds a finished beat while the next one is computed;
// if res_o stalls, cmd_i stays ready until a second result is due, then waits.
// Reset: both envelopes stopped, tint and overlay state zero, all times zero,
// fade color all ones, result register empty.
module trapezoid_fade_envelope #(
  parameter int unsigned LevelFracBits = tfe_pkg::LEVEL_FRAC_BITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tfe_cfg_if.sink    cfg_i,
  tfe_cmd_if.sink    cmd_i,
  tfe_res_if.source  res_o
);

  tfe_pkg::ctrl_cmd_t ctrl;
  tfe_pkg::ctrl_sts_t sts;

  assign cfg_i.ready = 1'b1;

  tfe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_i.valid),
    .cmd_ready_o (cmd_i.ready),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .sts_i       (sts),
    .ctrl_o      (ctrl)
  );

  tfe_datapath #(
    .LevelFracBits (LevelFracBits)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_i.valid),
    .cfg_idx_i       (cfg_i.index),
    .cfg_data_i      (cfg_i.data),
    .cmd_i           (cmd_i.cmd),
    .ticks_i         (cmd_i.elapsed_ticks),
    .ctrl_i          (ctrl),
    .sts_o           (sts),
    .tint_enable_o   (res_o.tint_enable),
    .tint_level_o    (res_o.tint_level),
    .overlay_color_o (res_o.overlay_color),
    .out_active_o    (res_o.out_active),
    .in_active_o     (res_o.in_active)
  );

endmodule

// ----- verif/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LVL_W          = tfe_pkg::LEVEL_FRAC_BITS + 1;
  localparam longint unsigned LVL_ONE    = 64'd1 << tfe_pkg::LEVEL_FRAC_BITS;
  localparam int unsigned TW             = tfe_pkg::TIME_W;
  localparam int unsigned CW             = tfe_pkg::COLOR_W;
  localparam int unsigned RANDOM_ITEMS   = 400;
  localparam int unsigned DRAIN_CYCLES   = 50;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  typedef struct {
    logic             tint_enable;
    logic [LVL_W-1:0] tint_level;
    logic [31:0]      overlay_color;
    logic             out_active;
    logic             in_active;
  } fade_result_t;

  class fade_scoreboard;
    logic [TW-1:0]                 out_rise, out_hold, out_fall;
    logic [TW-1:0]                 in_rise, in_hold, in_fall;
    logic [CW-1:0]                 color;
    logic [tfe_pkg::ELAPSED_W-1:0] out_elapsed, in_elapsed;
    bit                            out_run, in_run, tint_on;
    logic [LVL_W-1:0]              tint_value;
    logic [CW-1:0]                 overlay;
    fade_result_t                  expected_q[$];
    int unsigned                   errors;

    function new();
      out_rise    = '0;
      out_hold    = '0;
      out_fall    = '0;
      in_rise     = '0;
      in_hold     = '0;
      in_fall     = '0;
      color       = tfe_pkg::COLOR_RESET;
      out_elapsed = '0;
      in_elapsed  = '0;
      out_run     = 1'b0;
      in_run      = 1'b0;
      tint_on     = 1'b0;
      tint_value  = '0;
      overlay     = '0;
      errors      = 0;
    endfunction

    function void write_reg(logic [tfe_pkg::CFG_IDX_W-1:0] idx,
                            logic [tfe_pkg::CFG_DATA_W-1:0] data);
      case (tfe_pkg::cfg_idx_e'(idx))
        tfe_pkg::CFG_OUT_RISE: out_rise = data[TW-1:0];
        tfe_pkg::CFG_OUT_HOLD: out_hold = data[TW-1:0];
        tfe_pkg::CFG_OUT_FALL: out_fall = data[TW-1:0];
        tfe_pkg::CFG_IN_RISE:  in_rise  = data[TW-1:0];
        tfe_pkg::CFG_IN_HOLD:  in_hold  = data[TW-1:0];
        tfe_pkg::CFG_IN_FALL:  in_fall  = data[TW-1:0];
        tfe_pkg::CFG_COLOR:    color    = data;
        default: ;
      endcase
    endfunction

    // 0 when the level is undefined (no fall time) or below zero
    function bit ramp_level(int unsigned e, int unsigned r, int unsigned h,
                            int unsigned f, output longint unsigned lvl);
      int unsigned d;
      longint unsigned num;
      lvl = 0;
      if (e >= r + h) begin
        d = e - r - h;
        if (f == 0 || d > f) return 1'b0;
        num = f - d;
        lvl = (num << tfe_pkg::LEVEL_FRAC_BITS) / f;
        return 1'b1;
      end
      if (e <= r) begin
        num = e;
        lvl = (r == 0) ? LVL_ONE : (num << tfe_pkg::LEVEL_FRAC_BITS) / r;
      end else begin
        lvl = LVL_ONE;
      end
      return 1'b1;
    endfunction

    function logic [CW-1:0] scale_color(longint unsigned lvl);
      logic [CW-1:0] res;
      longint unsigned ch;
      longint unsigned v;
      res = '0;
      for (int k = 0; k < 4; k++) begin
        ch = color[8*k +: 8];
        v  = (ch * lvl) >> tfe_pkg::LEVEL_FRAC_BITS;
        res[8*k +: 8] = v[7:0];
      end
      return res;
    endfunction

    function void advance_out(logic [TW-1:0] t);
      longint unsigned lvl;
      int unsigned total;
      if (!out_run) return;
      if (out_rise == 0) begin
        out_run     = 1'b0;
        out_elapsed = '0;
        return;
      end
      out_elapsed = out_elapsed + t;
      if (ramp_level(out_elapsed, out_rise, out_hold, out_fall, lvl)) begin
        tint_on    = 1'b1;
        tint_value = lvl[LVL_W-1:0];
      end
      total = out_rise + out_hold + out_fall;
      if (out_elapsed >= total) begin
        tint_on     = 1'b0;
        out_run     = 1'b0;
        out_elapsed = '0;
      end
    endfunction

    function void advance_in(logic [TW-1:0] t);
      longint unsigned lvl;
      int unsigned total;
      if (!in_run) return;
      if (in_rise == 0) begin
        in_run     = 1'b0;
        in_elapsed = '0;
        return;
      end
      in_elapsed = in_elapsed + t;
      if (!ramp_level(in_elapsed, in_rise, in_hold, in_fall, lvl)) lvl = 0;
      if (lvl > LVL_ONE) lvl = LVL_ONE;
      overlay = scale_color(lvl);
      total = in_rise + in_hold + in_fall;
      if (in_elapsed >= total) begin
        overlay    = '0;
        in_run     = 1'b0;
        in_elapsed = '0;
      end
    endfunction

    function void note_cmd(logic [tfe_pkg::CMD_W-1:0] c, logic [TW-1:0] t);
      fade_result_t r;
      case (tfe_pkg::cmd_e'(c))
        tfe_pkg::CMD_TICK: begin
          advance_out(t);
          advance_in(t);
        end
        tfe_pkg::CMD_ARM_OUT: begin
          out_elapsed = '0;
          out_run     = (out_rise != 0);
        end
        tfe_pkg::CMD_ARM_IN: begin
          in_elapsed = '0;
          in_run     = (in_rise != 0);
        end
        default: ;
      endcase
      r.tint_enable   = tint_on;
      r.tint_level    = tint_value;
      r.overlay_color = overlay;
      r.out_active    = out_run;
      r.in_active     = in_run;
      expected_q.push_back(r);
    endfunction

    function void check_result(fade_result_t got);
      fade_result_t want;
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.tint_enable !== want.tint_enable) begin
        $error("tint_enable: expected %0d, got %0d", want.tint_enable, got.tint_enable);
        errors++;
      end
      if (got.tint_level !== want.tint_level) begin
        $error("tint_level: expected 0x%0h, got 0x%0h", want.tint_level, got.tint_level);
        errors++;
      end
      if (got.overlay_color !== want.overlay_color) begin
        $error("overlay_color: expected 0x%08h, got 0x%08h",
               want.overlay_color, got.overlay_color);
        errors++;
      end
      if (got.out_active !== want.out_active) begin
        $error("out_active: expected %0d, got %0d", want.out_active, got.out_active);
        errors++;
      end
      if (got.in_active !== want.in_active) begin
        $error("in_active: expected %0d, got %0d", want.in_active, got.in_active);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  tfe_cmd_if cmd_if ();
  tfe_res_if res_if ();
  tfe_cfg_if cfg_if ();

  trapezoid_fade_envelope u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .cmd_i  (cmd_if),
    .res_o  (res_if)
  );

  fade_scoreboard sb;
  fade_result_t   res_beat;
  int unsigned    burst_left = 0;
  logic [7:0]     stall_phase = '0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver: open, coin flip, one in four, mostly open
  always @(posedge clk_i) begin
    stall_phase <= stall_phase + 8'd1;
    if (rst_ni !== 1'b1) begin
      res_if.ready <= 1'b0;
    end else begin
      case (stall_phase[7:6])
        2'd0: res_if.ready <= 1'b1;
        2'd1: res_if.ready <= 1'($urandom_range(0, 1));
        2'd2: res_if.ready <= (stall_phase[1:0] == 2'd0);
        default: res_if.ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (cfg_if.valid && cfg_if.ready) sb.write_reg(cfg_if.index, cfg_if.data);
      if (cmd_if.valid && cmd_if.ready) sb.note_cmd(cmd_if.cmd, cmd_if.elapsed_ticks);
      if (res_if.valid && res_if.ready) begin
        res_beat.tint_enable   = res_if.tint_enable;
        res_beat.tint_level    = res_if.tint_level;
        res_beat.overlay_color = res_if.overlay_color;
        res_beat.out_active    = res_if.out_active;
        res_beat.in_active     = res_if.in_active;
        sb.check_result(res_beat);
      end
    end
  end

  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_cmd(tfe_pkg::cmd_e c, logic [TW-1:0] t);
    if (burst_left == 0) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
    cmd_if.valid         <= 1'b1;
    cmd_if.cmd           <= c;
    cmd_if.elapsed_ticks <= t;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    burst_left--;
  endtask

  task automatic put_reg(tfe_pkg::cfg_idx_e idx, logic [tfe_pkg::CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
  endtask

  // waits for the block to drain, then rewrites every register
  task automatic configure(logic [TW-1:0] o_r, logic [TW-1:0] o_h,
                           logic [TW-1:0] o_f, logic [TW-1:0] i_r,
                           logic [TW-1:0] i_h, logic [TW-1:0] i_f,
                           logic [CW-1:0] color);
    cmd_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    put_reg(tfe_pkg::CFG_OUT_RISE, {16'($urandom), o_r});
    put_reg(tfe_pkg::CFG_OUT_HOLD, {16'($urandom), o_h});
    put_reg(tfe_pkg::CFG_OUT_FALL, {16'($urandom), o_f});
    put_reg(tfe_pkg::CFG_IN_RISE,  {16'($urandom), i_r});
    put_reg(tfe_pkg::CFG_IN_HOLD,  {16'($urandom), i_h});
    put_reg(tfe_pkg::CFG_IN_FALL,  {16'($urandom), i_f});
    put_reg(tfe_pkg::CFG_COLOR,    color);
    put_reg(tfe_pkg::CFG_NONE,     32'($urandom));
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [TW-1:0] pick_time(int unsigned mode, bit is_rise);
    if (is_rise && $urandom_range(0, 9) == 0) return '0;
    case (mode)
      0: return is_rise ? TW'($urandom_range(1, 12)) : TW'($urandom_range(0, 12));
      1: return TW'($urandom_range(0, 2000));
      2: return TW'($urandom);
      default: begin
        case ($urandom_range(0, 2))
          0: return is_rise ? 16'hFFFF : 16'h0000;
          1: return 16'h0001;
          default: return 16'hFFFF;
        endcase
      end
    endcase
  endfunction

  initial begin
    int unsigned sent;
    int unsigned mode;
    int unsigned span;
    int unsigned step;
    int unsigned n;
    int unsigned roll;
    logic [TW-1:0] t_or, t_oh, t_of, t_ir, t_ih, t_if;
    logic [CW-1:0] col;
    logic [TW-1:0] ticks;
    tfe_pkg::cmd_e c;

    sb = new();
    rst_ni               <= 1'b0;
    cmd_if.valid         <= 1'b0;
    cmd_if.cmd           <= tfe_pkg::CMD_TICK;
    cmd_if.elapsed_ticks <= '0;
    cfg_if.valid         <= 1'b0;
    cfg_if.index         <= tfe_pkg::CFG_NONE;
    cfg_if.data          <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: zero rise keeps both envelopes stopped
    send_cmd(tfe_pkg::CMD_ARM_OUT, 16'h0000);
    send_cmd(tfe_pkg::CMD_ARM_IN,  16'hFFFF);
    send_cmd(tfe_pkg::CMD_TICK,    16'hFFFF);
    send_cmd(tfe_pkg::CMD_RSVD,    16'hFFFF);

    // walk through rise, hold, fall and completion; fade-in with no fall time
    configure(16'd4, 16'd2, 16'd4, 16'd8, 16'd0, 16'd0, 32'h80FF_7F01);
    send_cmd(tfe_pkg::CMD_ARM_OUT, 16'd0);
    send_cmd(tfe_pkg::CMD_ARM_IN,  16'd0);
    send_cmd(tfe_pkg::CMD_TICK,    16'd0);
    send_cmd(tfe_pkg::CMD_TICK,    16'd2);
    send_cmd(tfe_pkg::CMD_TICK,    16'd2);
    send_cmd(tfe_pkg::CMD_TICK,    16'd1);
    send_cmd(tfe_pkg::CMD_TICK,    16'd1);
    send_cmd(tfe_pkg::CMD_TICK,    16'd3);
    send_cmd(tfe_pkg::CMD_TICK,    16'd1);

    // largest fade-out times and largest ticks, black color
    configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1, 16'd0, 16'hFFFF, 32'h0000_0000);
    send_cmd(tfe_pkg::CMD_ARM_OUT, 16'hFFFF);
    send_cmd(tfe_pkg::CMD_ARM_IN,  16'hFFFF);
    send_cmd(tfe_pkg::CMD_TICK,    16'hFFFF);
    send_cmd(tfe_pkg::CMD_TICK,    16'hFFFF);
    send_cmd(tfe_pkg::CMD_TICK,    16'hFFFF);

    // fall ends exactly on level zero; fade-in left on the rise
    configure(16'd1, 16'd0, 16'd1, 16'd3, 16'd1, 16'd0, 32'hFFFF_FFFF);
    send_cmd(tfe_pkg::CMD_ARM_OUT, 16'd0);
    send_cmd(tfe_pkg::CMD_ARM_IN,  16'd0);
    send_cmd(tfe_pkg::CMD_TICK,    16'd2);

    // overshoot past the fall; fade-in rise cleared while running
    configure(16'd1, 16'd0, 16'd1, 16'd0, 16'd1, 16'd0, 32'h1234_5678);
    send_cmd(tfe_pkg::CMD_ARM_OUT, 16'd0);
    send_cmd(tfe_pkg::CMD_TICK,    16'd5);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      mode = $urandom_range(0, 3);
      t_or = pick_time(mode, 1'b1);
      t_oh = pick_time(mode, 1'b0);
      t_of = pick_time(mode, 1'b0);
      t_ir = pick_time(mode, 1'b1);
      t_ih = pick_time(mode, 1'b0);
      t_if = pick_time(mode, 1'b0);
      case ($urandom_range(0, 5))
        0: col = 32'h0000_0000;
        1: col = 32'hFFFF_FFFF;
        default: col = $urandom;
      endcase
      configure(t_or, t_oh, t_of, t_ir, t_ih, t_if, col);

      span = t_or + t_oh + t_of;
      if (t_ir + t_ih + t_if > span) span = t_ir + t_ih + t_if;
      step = span / 6 + 1;
      if (step > 65535) step = 65535;

      if ($urandom_range(0, 3) != 0) begin
        send_cmd(tfe_pkg::CMD_ARM_OUT, TW'($urandom));
        send_cmd(tfe_pkg::CMD_ARM_IN,  TW'($urandom));
        sent += 2;
      end

      n = $urandom_range(15, 40);
      repeat (n) begin
        roll = $urandom_range(0, 99);
        if (roll < 3)
          c = tfe_pkg::CMD_RSVD;
        else if (roll < 8 || (!sb.out_run && roll < 30))
          c = tfe_pkg::CMD_ARM_OUT;
        else if (roll < 13 || (!sb.in_run && roll < 50))
          c = tfe_pkg::CMD_ARM_IN;
        else
          c = tfe_pkg::CMD_TICK;
        case ($urandom_range(0, 19))
          0: ticks = TW'($urandom);
          1: ticks = '0;
          2: ticks = 16'hFFFF;
          default: ticks = TW'($urandom_range(0, step));
        endcase
        send_cmd(c, ticks);
        if (c != tfe_pkg::CMD_RSVD) sent++;
      end
    end

    cmd_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
